>>> rtl/nacc_pkg.sv
// ----------------------------------------------------------------------------
// nacc_pkg
// Shared types, register indexes and the step offset table of the nibble
// accumulator with shift register.
// ----------------------------------------------------------------------------
`default_nettype none

package nacc_pkg;

   localparam int unsigned NibbleWidth = 4;
   localparam int unsigned SumWidth    = 6;
   localparam int unsigned DataWidth   = 32;
   localparam int unsigned AddrWidth   = 5;
   localparam int unsigned IndexWidth  = 3;

   typedef enum logic [IndexWidth-1:0] {
      CSR_ADD_VALUE           = 3'd0,
      CSR_SUBTRACT_MODE       = 3'd1,
      CSR_ASYNC_MODE          = 3'd2,
      CSR_EXTERNAL_SHIFT_DATA = 3'd3,
      CSR_OFFSET_SELECT       = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [NibbleWidth-1:0] add_value;
      logic                   subtract_mode;
      logic                   async_mode;
      logic                   external_shift_data;
      logic [1:0]             offset_select;
   } cfg_type;

   typedef struct packed {
      logic [NibbleWidth-1:0] gate_bits;
      logic                   carry_in;
      logic                   clock_level;
      logic                   shift_level;
      logic                   shift_data_level;
      logic                   xor_level;
      logic                   reset_level;
      logic                   sub_level;
   } req_type;

   typedef struct packed {
      logic [NibbleWidth-1:0] out_bits;
      logic                   carry_out;
      logic [NibbleWidth-1:0] step_value;
      logic [NibbleWidth-1:0] offset_step_value;
   } rsp_type;

   function automatic logic [NibbleWidth-1:0] step_offset(input logic [1:0] sel);
      logic [NibbleWidth-1:0] value;
      case (sel)
         2'd0:    value = 4'd0;
         2'd1:    value = 4'd4;
         2'd2:    value = 4'd2;
         2'd3:    value = 4'd8;
         default: value = 4'd0;
      endcase
      return value;
   endfunction

endpackage

`default_nettype wire

>>> rtl/nacc_if.sv
// ----------------------------------------------------------------------------
// nacc_if
// Valid/ready stream interfaces for the request and response channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface nacc_req_if;
   logic              valid;
   logic              ready;
   nacc_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface nacc_rsp_if;
   logic              valid;
   logic              ready;
   nacc_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> rtl/nibble_accumulator_shift_register.sv
// ----------------------------------------------------------------------------
// nibble_accumulator_shift_register
// Four-bit accumulator with shift register, one sample of levels per transfer.
//
//   Channel   Direction  Handshake          Contents
//   req_ch    in         valid/ready        one sample of gate and control levels
//   rsp_ch    out        valid/ready        output bits, carry, step values
//   csr (APB) in         psel/penable       five configuration registers
//
// A sample is captured in an input register and then processed into the
// result register; one sample is accepted every cycle while the response
// is not stalled. Reset is synchronous and clears the held nibble, the
// edge history and the configuration. A stalled response holds both
// registers, and the input side still accepts one sample while the result
// register waits.
// ----------------------------------------------------------------------------
`default_nettype none

module nibble_accumulator_shift_register (
   input  wire logic                           clock,
   input  wire logic                           reset,
   nacc_req_if.sink                            req_ch,
   nacc_rsp_if.source                          rsp_ch,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [nacc_pkg::AddrWidth-1:0] paddr,
   input  wire logic [nacc_pkg::DataWidth-1:0] pwdata,
   output logic      [nacc_pkg::DataWidth-1:0] prdata,
   output logic                                pready
);

   nacc_pkg::cfg_type cfg;
   nacc_pkg::req_type in_data_ff;
   logic              in_valid_ff;
   nacc_pkg::rsp_type result;
   nacc_pkg::rsp_type out_data_ff;
   logic              out_valid_ff;
   logic              advance;
   logic              fire;

   nacc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   nacc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .item    (in_data_ff),
      .advance (fire),
      .result  (result)
   );

   assign advance       = !out_valid_ff || rsp_ch.ready;
   assign fire          = in_valid_ff && advance;
   assign req_ch.ready  = !in_valid_ff || advance;
   assign rsp_ch.valid   = out_valid_ff;
   assign rsp_ch.payload = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ch.ready) begin
            in_valid_ff <= req_ch.valid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_data_ff <= req_ch.payload;
      end
      if (fire) begin
         out_data_ff <= result;
      end
   end

endmodule

`default_nettype wire

>>> rtl/nacc_csr.sv
// ----------------------------------------------------------------------------
// nacc_csr
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module nacc_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [nacc_pkg::AddrWidth-1:0]      paddr,
   input  wire logic [nacc_pkg::DataWidth-1:0]      pwdata,
   output logic      [nacc_pkg::DataWidth-1:0]      prdata,
   output logic                                     pready,
   output nacc_pkg::cfg_type                        cfg
);

   nacc_pkg::cfg_type       cfg_ff;
   nacc_pkg::cfg_type       cfg_in;
   nacc_pkg::csr_index_type index;
   logic                    write_en;

   assign index    = nacc_pkg::csr_index_type'(paddr[nacc_pkg::AddrWidth-1:2]);
   assign write_en = psel && penable && pwrite;
   assign pready   = 1'b1;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            nacc_pkg::CSR_ADD_VALUE:           cfg_in.add_value = pwdata[3:0];
            nacc_pkg::CSR_SUBTRACT_MODE:       cfg_in.subtract_mode = pwdata[0];
            nacc_pkg::CSR_ASYNC_MODE:          cfg_in.async_mode = pwdata[0];
            nacc_pkg::CSR_EXTERNAL_SHIFT_DATA: cfg_in.external_shift_data = pwdata[0];
            nacc_pkg::CSR_OFFSET_SELECT:       cfg_in.offset_select = pwdata[1:0];
            default:                           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      case (index)
         nacc_pkg::CSR_ADD_VALUE:           prdata[3:0] = cfg_ff.add_value;
         nacc_pkg::CSR_SUBTRACT_MODE:       prdata[0]   = cfg_ff.subtract_mode;
         nacc_pkg::CSR_ASYNC_MODE:          prdata[0]   = cfg_ff.async_mode;
         nacc_pkg::CSR_EXTERNAL_SHIFT_DATA: prdata[0]   = cfg_ff.external_shift_data;
         nacc_pkg::CSR_OFFSET_SELECT:       prdata[1:0] = cfg_ff.offset_select;
         default:                           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/nacc_core.sv
// ----------------------------------------------------------------------------
// nacc_core
// Accumulator datapath: sum, negation, register load and shift, and the
// edge and feedback state that carries from one sample to the next.
// ----------------------------------------------------------------------------
`default_nettype none

module nacc_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire nacc_pkg::cfg_type cfg,
   input  wire nacc_pkg::req_type item,
   input  wire logic              advance,
   output nacc_pkg::rsp_type      result
);

   localparam int unsigned NW = nacc_pkg::NibbleWidth;
   localparam int unsigned SW = nacc_pkg::SumWidth;

   logic [NW-1:0] held_ff;
   logic [NW-1:0] held_in;
   logic          prev_clock_ff;
   logic          prev_shift_ff;
   logic          last_bit_eight_ff;
   logic          last_bit_eight_in;

   logic [NW:0]   base_sum;
   logic [NW:0]   adj_sum;
   logic [SW-1:0] sum;
   logic          load;
   logic          data_bit;
   logic [NW-1:0] loaded;
   logic [NW-1:0] word_low;

   always_comb begin
      base_sum = {1'b0, item.gate_bits} + {{NW{1'b0}}, item.carry_in}
               + {1'b0, cfg.add_value};
      if (item.sub_level != cfg.subtract_mode) begin
         adj_sum = 5'd16 - {1'b0, base_sum[NW-1:0]};
      end else begin
         adj_sum = base_sum;
      end
      sum = {1'b0, adj_sum} + {2'b00, held_ff};

      load = (item.clock_level && !prev_clock_ff)
          || (cfg.async_mode && item.shift_level && !prev_shift_ff);
      data_bit = (cfg.external_shift_data ? item.shift_data_level : last_bit_eight_ff)
               ^ item.xor_level;
      if (item.shift_level) begin
         loaded = {sum[NW-2:0], data_bit};
      end else begin
         loaded = sum[NW-1:0];
      end

      held_in = held_ff;
      if (load) begin
         held_in = loaded;
      end
      if (item.reset_level) begin
         held_in = '0;
      end

      word_low = cfg.async_mode ? sum[NW-1:0] : held_in;
      last_bit_eight_in = word_low[NW-1];

      result.out_bits          = word_low;
      result.carry_out         = sum[NW];
      result.step_value        = word_low;
      result.offset_step_value = word_low + nacc_pkg::step_offset(cfg.offset_select);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff           <= '0;
         prev_clock_ff     <= 1'b0;
         prev_shift_ff     <= 1'b0;
         last_bit_eight_ff <= 1'b0;
      end else if (advance) begin
         held_ff           <= held_in;
         prev_clock_ff     <= item.clock_level;
         prev_shift_ff     <= item.shift_level;
         last_bit_eight_ff <= last_bit_eight_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/nacc_checker.sv
// ----------------------------------------------------------------------------
// nacc_checker
// Port-level checks on the accumulator, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module nacc_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire nacc_pkg::rsp_type rsp_payload
);

   // The input side only stalls when a finished result is held back.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("request stalled without a blocked response");

   // Both step outputs come from the same output word.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.out_bits == rsp_payload.step_value))
      else $error("step value differs from output bits");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(rsp_payload))
      else $error("response payload changed while stalled");

endmodule

bind nibble_accumulator_shift_register nacc_checker u_nacc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_payload (rsp_ch.payload)
);

`default_nettype wire

>>> tb/nacc_tb_pkg.sv
// ----------------------------------------------------------------------------
// nacc_tb_pkg
// Scoreboard for the nibble accumulator with shift register. It keeps its
// own copy of the configuration and the held state, predicts the result of
// every accepted sample and compares each returned result field by field
// with the oldest prediction.
// ----------------------------------------------------------------------------
package nacc_tb_pkg;

   import nacc_pkg::*;

   class nibble_scoreboard;
      cfg_type     cfg;
      logic [3:0]  held;
      logic        prev_clock;
      logic        prev_shift;
      logic        last_bit3;
      rsp_type     pending_results[$];
      int unsigned mismatches;
      int unsigned samples;
      int unsigned results;

      function new();
         cfg        = '0;
         held       = '0;
         prev_clock = 1'b0;
         prev_shift = 1'b0;
         last_bit3  = 1'b0;
         mismatches = 0;
         samples    = 0;
         results    = 0;
      endfunction

      function void write_register(csr_index_type index, logic [31:0] value);
         case (index)
            CSR_ADD_VALUE:           cfg.add_value           = value[3:0];
            CSR_SUBTRACT_MODE:       cfg.subtract_mode       = value[0];
            CSR_ASYNC_MODE:          cfg.async_mode          = value[0];
            CSR_EXTERNAL_SHIFT_DATA: cfg.external_shift_data = value[0];
            CSR_OFFSET_SELECT:       cfg.offset_select       = value[1:0];
            default: ;
         endcase
      endfunction

      function void note_sample(req_type s);
         logic [5:0] sum;
         logic [4:0] word;
         logic [3:0] loaded;
         logic [3:0] offset;
         logic       load;
         logic       serial;
         rsp_type    r;
         sum = {2'b00, s.gate_bits} + {5'b00000, s.carry_in} + {2'b00, cfg.add_value};
         if (s.sub_level != cfg.subtract_mode) begin
            sum = 6'd16 - {2'b00, sum[3:0]};
         end
         sum = sum + {2'b00, held};
         load = s.clock_level && !prev_clock;
         if (cfg.async_mode && s.shift_level && !prev_shift) begin
            load = 1'b1;
         end
         serial = (cfg.external_shift_data ? s.shift_data_level : last_bit3) ^ s.xor_level;
         if (load) begin
            loaded = sum[3:0];
            if (s.shift_level) begin
               loaded = {loaded[2:0], serial};
            end
            held = loaded;
         end
         if (s.reset_level) begin
            held = 4'd0;
         end
         word = cfg.async_mode ? sum[4:0] : {sum[4], held};
         prev_clock = s.clock_level;
         prev_shift = s.shift_level;
         last_bit3  = word[3];
         case (cfg.offset_select)
            2'd0:    offset = 4'd0;
            2'd1:    offset = 4'd4;
            2'd2:    offset = 4'd2;
            default: offset = 4'd8;
         endcase
         r.out_bits          = word[3:0];
         r.carry_out         = word[4];
         r.step_value        = word[3:0];
         r.offset_step_value = word[3:0] + offset;
         pending_results.push_back(r);
         samples++;
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         logic    bad;
         results++;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("result with no sample waiting: out %h carry %b step %h offset %h",
                        got.out_bits, got.carry_out, got.step_value, got.offset_step_value);
            end
         end else begin
            want = pending_results.pop_front();
            bad = (got.out_bits !== want.out_bits) || (got.carry_out !== want.carry_out) ||
                  (got.step_value !== want.step_value) ||
                  (got.offset_step_value !== want.offset_step_value);
            if (bad) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("result %0d: out %h/%h carry %b/%b step %h/%h offset %h/%h (exp/got)",
                           results, want.out_bits, got.out_bits, want.carry_out,
                           got.carry_out, want.step_value, got.step_value,
                           want.offset_step_value, got.offset_step_value);
               end
            end
         end
      endfunction

      function int unsigned outstanding();
         return pending_results.size();
      endfunction
   endclass

endpackage

>>> tb/tb_nibble_accumulator_shift_register.sv
// ----------------------------------------------------------------------------
// tb_nibble_accumulator_shift_register
// Drives samples of levels into the accumulator under a series of register
// settings, with random idling on both channels and one long receiver
// hold-off, and checks every result against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module tb_nibble_accumulator_shift_register;

   timeunit 1ns;
   timeprecision 1ps;

   import nacc_pkg::*;
   import nacc_tb_pkg::*;

   localparam int unsigned IdleLimit     = 2000;
   localparam int unsigned HoldOffCycles = 300;
   localparam int unsigned SegmentItems  = 80;
   localparam int unsigned SegmentCount  = 12;
   localparam int unsigned DrainCycles   = 8;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 psel;
   logic                 penable;
   logic                 pwrite;
   logic [AddrWidth-1:0] paddr;
   logic [DataWidth-1:0] pwdata;
   logic [DataWidth-1:0] prdata;
   logic                 pready;

   nacc_req_if req_ch ();
   nacc_rsp_if rsp_ch ();

   nibble_scoreboard board = new();

   int unsigned send_idle_pct = 38;
   int unsigned recv_idle_pct = 79;
   bit          hold_request  = 1'b0;
   int unsigned idle_cycles   = 0;
   int unsigned settings_used = 0;

   nibble_accumulator_shift_register u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            board.note_sample(req_ch.payload);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            board.check_result(rsp_ch.payload);
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (psel && penable)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IdleLimit) begin
            $display("no transfer for %0d cycles", IdleLimit);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_ch.ready <= 1'b0;
            repeat (HoldOffCycles) @(posedge clock);
            hold_request = 1'b0;
         end
         rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   function automatic req_type make_sample(logic [3:0] gate, logic cin, logic clk, logic shf,
                                           logic sdata, logic xr, logic rst, logic sub);
      req_type s;
      s.gate_bits        = gate;
      s.carry_in         = cin;
      s.clock_level      = clk;
      s.shift_level      = shf;
      s.shift_data_level = sdata;
      s.xor_level        = xr;
      s.reset_level      = rst;
      s.sub_level        = sub;
      return s;
   endfunction

   function automatic req_type random_sample();
      return make_sample(4'($urandom_range(0, 15)), 1'($urandom), 1'($urandom),
                         $urandom_range(0, 99) < 35, 1'($urandom), 1'($urandom),
                         $urandom_range(0, 99) < 8, $urandom_range(0, 99) < 40);
   endfunction

   task automatic send_item(input req_type item);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= item;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (board.outstanding() != 0);
   endtask

   task automatic write_setting(input csr_index_type index, input logic [3:0] value);
      logic [31:0] junk;
      logic [31:0] data;
      junk = $urandom;
      case (index)
         CSR_ADD_VALUE:     data = {junk[31:4], value};
         CSR_OFFSET_SELECT: data = {junk[31:2], value[1:0]};
         default:           data = {junk[31:1], value[0]};
      endcase
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      board.write_register(index, data);
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [3:0] add, input logic sub, input logic async,
                                 input logic ext, input logic [1:0] ofs);
      write_setting(CSR_ADD_VALUE, add);
      write_setting(CSR_SUBTRACT_MODE, {3'b000, sub});
      write_setting(CSR_ASYNC_MODE, {3'b000, async});
      write_setting(CSR_EXTERNAL_SHIFT_DATA, {3'b000, ext});
      write_setting(CSR_OFFSET_SELECT, {2'b00, ofs});
      settings_used++;
   endtask

   initial begin
      int unsigned seg;
      int unsigned k;
      int unsigned errors;
      logic [3:0]  add;
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.payload <= '0;
      psel           <= 1'b0;
      penable        <= 1'b0;
      pwrite         <= 1'b0;
      paddr          <= '0;
      pwdata         <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Synchronous mode with feedback data and the largest addend.
      apply_settings(4'd15, 1'b0, 1'b0, 1'b0, 2'd3);
      send_item(make_sample(4'd0, 0, 0, 0, 0, 0, 0, 0));
      send_item(make_sample(4'd15, 1, 1, 0, 0, 0, 0, 0));
      send_item(make_sample(4'd15, 1, 0, 0, 0, 0, 0, 0));
      send_item(make_sample(4'd15, 1, 1, 1, 0, 0, 0, 0));
      send_item(make_sample(4'd0, 0, 0, 0, 0, 0, 0, 0));
      send_item(make_sample(4'd3, 0, 0, 1, 1, 1, 0, 0));
      send_item(make_sample(4'd0, 0, 0, 0, 0, 0, 0, 1));
      send_item(make_sample(4'd5, 1, 1, 0, 0, 0, 0, 1));
      send_item(make_sample(4'd9, 0, 0, 1, 0, 1, 0, 0));
      send_item(make_sample(4'd9, 0, 1, 1, 0, 1, 0, 0));
      send_item(make_sample(4'd15, 1, 1, 0, 1, 1, 1, 1));
      send_item(make_sample(4'd0, 0, 0, 0, 0, 0, 1, 0));
      drain();

      // Asynchronous mode, external data, inverted subtract sense.
      apply_settings(4'd0, 1'b1, 1'b1, 1'b1, 2'd1);
      send_item(make_sample(4'd0, 0, 0, 0, 0, 0, 0, 0));
      send_item(make_sample(4'd15, 1, 0, 1, 1, 0, 0, 0));
      send_item(make_sample(4'd15, 1, 0, 0, 0, 0, 0, 1));
      send_item(make_sample(4'd7, 0, 1, 0, 0, 1, 0, 1));
      send_item(make_sample(4'd7, 1, 1, 1, 1, 1, 0, 0));
      send_item(make_sample(4'd0, 1, 0, 0, 0, 0, 0, 1));
      send_item(make_sample(4'd10, 0, 1, 1, 0, 0, 1, 0));
      send_item(make_sample(4'd15, 1, 0, 0, 1, 1, 0, 1));
      drain();

      apply_settings(4'd15, 1'b0, 1'b1, 1'b0, 2'd2);
      send_item(make_sample(4'd15, 1, 1, 1, 0, 0, 0, 0));
      send_item(make_sample(4'd15, 1, 0, 0, 0, 1, 0, 0));
      send_item(make_sample(4'd15, 1, 1, 1, 0, 1, 0, 0));
      send_item(make_sample(4'd15, 1, 0, 0, 0, 0, 0, 0));
      drain();

      for (seg = 0; seg < SegmentCount; seg++) begin
         case (seg / 4)
            0: begin
               send_idle_pct = 38;
               recv_idle_pct = 79;
            end
            1: begin
               send_idle_pct = 79;
               recv_idle_pct = 38;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         add = (seg == 0) ? 4'd0 : (seg == 1) ? 4'd15 : 4'($urandom_range(0, 15));
         apply_settings(add, 1'($urandom), 1'((seg >> 1) & 1), 1'($urandom), 2'(seg % 4));
         if (seg == 8) begin
            hold_request = 1'b1;
         end
         for (k = 0; k < SegmentItems; k++) begin
            send_item(random_sample());
         end
         drain();
      end

      repeat (DrainCycles) @(posedge clock);
      errors = board.mismatches + board.outstanding();
      if (board.outstanding() != 0) begin
         $display("%0d results never arrived", board.outstanding());
      end
      $display("Checked %0d results from %0d samples under %0d register settings.",
               board.results, board.samples, settings_used);
      $display("Both channels idled at random; the receiver held off once for %0d cycles.",
               HoldOffCycles);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/nacc_pkg.sv
rtl/nacc_if.sv
rtl/nacc_csr.sv
rtl/nacc_core.sv
rtl/nibble_accumulator_shift_register.sv
rtl/nacc_checker.sv
tb/nacc_tb_pkg.sv
tb/tb_nibble_accumulator_shift_register.sv
